/* design/sdfs_pkg.sv */
// Shared types, constants and the hex digit table for the segment display frame serializer.
// No dependencies; every other design file refers to this package by scoped names.
package sdfs_pkg;

	// Default number of segment bytes an address frame may carry.
	localparam int MAX_DATA_BYTES_DEF = 4;

	// Depth of the frame queue between the front end and the slot sequencer.
	localparam int QUEUE_DEPTH = 2;

	// Number of segment fields present in one request.
	localparam int SEG_FIELDS = 4;

	// Bit slot counter value that stands for the acknowledge slot of a byte.
	localparam logic [3:0] BIT_ACK = 4'd8;

	// Reset values of the configuration registers.
	localparam logic [3:0] BRIGHTNESS_RST   = 4'd15;
	localparam logic [7:0] DATA_MODE_RST    = 8'h40;
	localparam logic [7:0] ADDRESS_BASE_RST = 8'hC0;
	localparam logic [7:0] DISPLAY_BASE_RST = 8'h80;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_BRIGHTNESS   = 2'd0,
		REG_DATA_MODE    = 2'd1,
		REG_ADDRESS_BASE = 2'd2,
		REG_DISPLAY_BASE = 2'd3
	} cfg_reg_t;

	// Frame selector codes.
	typedef enum logic [1:0] {
		FUNC_DATA_MODE = 2'd0,
		FUNC_ADDRESS   = 2'd1,
		FUNC_DISPLAY   = 2'd2,
		FUNC_NONE      = 2'd3
	} func_t;

	// Wire slot kinds.
	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_BIT   = 2'd1,
		KIND_ACK   = 2'd2,
		KIND_STOP  = 2'd3
	} slot_kind_t;

	// Slot sequencer states.
	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_DATA,
		SQ_STOP
	} sdfs_state_t;

	// One frame request.
	typedef struct packed {
		logic [1:0] func;
		logic [1:0] start_pos;
		logic [2:0] byte_count;
		logic       hex_mode;
		logic [7:0] seg_first;
		logic [7:0] seg_second;
		logic [7:0] seg_third;
		logic [7:0] seg_fourth;
	} sdfs_in_t;

	// One wire slot.
	typedef struct packed {
		slot_kind_t slot_kind;
		logic       line_released;
		logic       last_slot;
	} sdfs_out_t;

	// Fill status of the frame queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Seven-segment pattern of a hex digit; D uses the lowercase d pattern.
	function automatic logic [7:0] seg_digit(input logic [3:0] digit);
		logic [7:0] pattern;
		unique case (digit)
			4'h0: pattern = 8'h3F;
			4'h1: pattern = 8'h06;
			4'h2: pattern = 8'h5B;
			4'h3: pattern = 8'h4F;
			4'h4: pattern = 8'h66;
			4'h5: pattern = 8'h6D;
			4'h6: pattern = 8'h7D;
			4'h7: pattern = 8'h07;
			4'h8: pattern = 8'h7F;
			4'h9: pattern = 8'h6F;
			4'hA: pattern = 8'h77;
			4'hB: pattern = 8'h7C;
			4'hC: pattern = 8'h39;
			4'hD: pattern = 8'h5E;
			4'hE: pattern = 8'h79;
			default: pattern = 8'h71;
		endcase
		return pattern;
	endfunction

endpackage

/* design/sdfs_queue.sv */
// Small first-in first-out queue of frame descriptors.
// Depends on sdfs_pkg for the queue depth and the status struct.
module sdfs_queue #(
	parameter int DW    = 48,
	parameter int DEPTH = sdfs_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [DW-1:0]       wdata,
	input  logic                pop,
	output logic [DW-1:0]       rdata,
	output sdfs_pkg::q_status_t status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DW-1:0] entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	// Guard against pushing into a full queue or popping an empty one.
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rdata        = entry_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* design/sdfs_front.sv */
// Front end: configuration registers, request decode and frame byte assembly.
// Depends on sdfs_pkg; pushes one descriptor per frame into sdfs_queue.
module sdfs_front #(
	parameter int MAX_DATA_BYTES = sdfs_pkg::MAX_DATA_BYTES_DEF,
	localparam int NB = MAX_DATA_BYTES + 1,
	localparam int CW = $clog2(NB + 1),
	localparam int DW = NB * 8 + CW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  sdfs_pkg::sdfs_in_t  in_data,
	input  sdfs_pkg::q_status_t q_status,
	output logic                q_push,
	output logic [DW-1:0]       q_wdata
);

	logic [3:0]           brightness_q;
	logic [7:0]           data_mode_q;
	logic [7:0]           address_base_q;
	logic [7:0]           display_base_q;
	logic [NB-1:0][7:0]   frame_bytes;
	logic [CW-1:0]        frame_len;
	logic [3:0][7:0]      segs;
	logic [2:0]           seg_count;
	logic                 frame_kept;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q   <= sdfs_pkg::BRIGHTNESS_RST;
			data_mode_q    <= sdfs_pkg::DATA_MODE_RST;
			address_base_q <= sdfs_pkg::ADDRESS_BASE_RST;
			display_base_q <= sdfs_pkg::DISPLAY_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdfs_pkg::REG_BRIGHTNESS:   brightness_q   <= cfg_wdata[3:0];
				sdfs_pkg::REG_DATA_MODE:    data_mode_q    <= cfg_wdata;
				sdfs_pkg::REG_ADDRESS_BASE: address_base_q <= cfg_wdata;
				sdfs_pkg::REG_DISPLAY_BASE: display_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign segs = {in_data.seg_fourth, in_data.seg_third, in_data.seg_second,
		in_data.seg_first};

	// Segment byte count, saturated to the frame capacity.
	assign seg_count = (in_data.byte_count > 3'(MAX_DATA_BYTES)) ?
		3'(MAX_DATA_BYTES) : in_data.byte_count;

	// Decode the selector into the command byte and the frame length.
	always_comb begin
		frame_bytes = '0;
		frame_len   = CW'(1);
		frame_kept  = 1'b1;
		unique case (in_data.func)
			sdfs_pkg::FUNC_DATA_MODE: begin
				frame_bytes[0] = data_mode_q;
			end
			sdfs_pkg::FUNC_ADDRESS: begin
				frame_bytes[0] = address_base_q + {6'd0, in_data.start_pos};
				frame_len      = CW'(seg_count) + CW'(1);
			end
			sdfs_pkg::FUNC_DISPLAY: begin
				frame_bytes[0] = display_base_q + {4'd0, brightness_q};
			end
			default: begin
				frame_kept = 1'b0;
			end
		endcase
		// Segment bytes; positions past the request fields send zero, or the digit 0 pattern in hex mode.
		if (in_data.func == sdfs_pkg::FUNC_ADDRESS) begin
			for (int k = 1; k < NB; k++) begin
				logic [7:0] raw;
				raw = (k <= sdfs_pkg::SEG_FIELDS) ? segs[2'((k - 1) & 3)] : 8'h00;
				frame_bytes[k] = in_data.hex_mode ? sdfs_pkg::seg_digit(raw[3:0]) : raw;
			end
		end
	end

	// Unused selectors are taken and dropped without a queue entry.
	assign in_ready = !q_status.full;
	assign q_push   = in_valid && in_ready && frame_kept;
	assign q_wdata  = {frame_len, frame_bytes};

endmodule

/* design/sdfs_back.sv */
// Back end: slot sequencer that turns queued frame descriptors into wire slots.
// Depends on sdfs_pkg; pops descriptors from sdfs_queue and drives the output register.
module sdfs_back #(
	parameter int MAX_DATA_BYTES = sdfs_pkg::MAX_DATA_BYTES_DEF,
	localparam int NB = MAX_DATA_BYTES + 1,
	localparam int CW = $clog2(NB + 1),
	localparam int BW = $clog2(NB),
	localparam int DW = NB * 8 + CW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdfs_pkg::q_status_t q_status,
	input  logic [DW-1:0]       q_rdata,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output sdfs_pkg::sdfs_out_t out_data
);

	sdfs_pkg::sdfs_state_t state_q, state_d;
	logic [NB-1:0][7:0]    bytes_q;
	logic [CW-1:0]         len_q;
	logic [BW-1:0]         byte_idx_q, byte_idx_d;
	logic [3:0]            bit_idx_q, bit_idx_d;
	logic                  out_valid_q, out_valid_d;
	sdfs_pkg::sdfs_out_t   out_q, out_d;
	logic                  advance;
	logic [7:0]            cur_byte;

	// A new slot may be written whenever the output register is free or being emptied.
	assign advance  = !out_valid_q || out_ready;
	assign cur_byte = bytes_q[byte_idx_q];

	// Next state and slot generation.
	always_comb begin
		state_d     = state_q;
		byte_idx_d  = byte_idx_q;
		bit_idx_d   = bit_idx_q;
		out_valid_d = out_valid_q && !out_ready;
		out_d       = out_q;
		q_pop       = 1'b0;
		unique case (state_q)
			sdfs_pkg::SQ_IDLE: begin
				if (advance && !q_status.empty) begin
					q_pop       = 1'b1;
					byte_idx_d  = '0;
					bit_idx_d   = '0;
					out_valid_d = 1'b1;
					out_d       = '{sdfs_pkg::KIND_START, 1'b0, 1'b0};
					state_d     = sdfs_pkg::SQ_DATA;
				end
			end
			sdfs_pkg::SQ_DATA: begin
				if (advance) begin
					out_valid_d = 1'b1;
					if (bit_idx_q == sdfs_pkg::BIT_ACK) begin
						out_d     = '{sdfs_pkg::KIND_ACK, 1'b1, 1'b0};
						bit_idx_d = '0;
						if (CW'(byte_idx_q) + CW'(1) == len_q) begin
							state_d = sdfs_pkg::SQ_STOP;
						end else begin
							byte_idx_d = byte_idx_q + BW'(1);
						end
					end else begin
						out_d     = '{sdfs_pkg::KIND_BIT, cur_byte[bit_idx_q[2:0]], 1'b0};
						bit_idx_d = bit_idx_q + 4'd1;
					end
				end
			end
			sdfs_pkg::SQ_STOP: begin
				if (advance) begin
					out_valid_d = 1'b1;
					out_d       = '{sdfs_pkg::KIND_STOP, 1'b1, 1'b1};
					state_d     = sdfs_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = sdfs_pkg::SQ_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdfs_pkg::SQ_IDLE;
			byte_idx_q  <= '0;
			bit_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			byte_idx_q  <= byte_idx_d;
			bit_idx_q   <= bit_idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Frame and slot payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			{len_q, bytes_q} <= q_rdata;
		end
		out_q <= out_d;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* design/segment_display_frame_serializer.sv */
// Top level of the segment display frame serializer: front end, frame queue and slot sequencer.
// Depends on sdfs_pkg, sdfs_front, sdfs_queue and sdfs_back.
//
// Each accepted request with a used selector becomes one wire frame: a start slot, nine slots
// per byte (eight data bits LSB first, then an acknowledge slot) and a stop slot, so a frame of
// n bytes is 2 + 9n slots, at most 47 with four segment bytes. The slot sequencer emits one
// slot per cycle while the output side takes them and opens the next frame in the cycle right
// after a stop slot; that sequencer sets the sustained rate. The front end takes a request in
// any cycle in which the two-entry frame queue has room, and a request with the unused selector
// is taken and dropped without producing slots. Configuration writes take effect on the next
// request that is accepted.
module segment_display_frame_serializer #(
	parameter int MAX_DATA_BYTES = sdfs_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  sdfs_pkg::sdfs_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sdfs_pkg::sdfs_out_t out_data
);

	localparam int NB = MAX_DATA_BYTES + 1;
	localparam int CW = $clog2(NB + 1);
	localparam int DW = NB * 8 + CW;

	sdfs_pkg::q_status_t q_status;
	logic                q_push;
	logic                q_pop;
	logic [DW-1:0]       q_wdata;
	logic [DW-1:0]       q_rdata;

	// Request decode and frame assembly.
	sdfs_front #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_status (q_status),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	// Frame descriptor queue.
	sdfs_queue #(
		.DW   (DW),
		.DEPTH(sdfs_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.status(q_status)
	);

	// Slot sequencer and output register.
	sdfs_back #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_rdata  (q_rdata),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef ASSERT_OFF
	// The front end never pushes a frame into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("frame pushed into a full queue");

	// The sequencer never pops an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("frame popped from an empty queue");

	// A popped frame always appears as a start slot in the next cycle.
	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid && out_data.slot_kind == sdfs_pkg::KIND_START))
		else $error("popped frame did not open with a start slot");

	// The frame end flag marks exactly the stop slots.
	a_last_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_slot == (out_data.slot_kind == sdfs_pkg::KIND_STOP)))
		else $error("frame end flag does not match the stop slot");
`endif

endmodule
